### hw/rtl/crc16_frame_receiver_with_ack_top_macros.svh
// Assertion macros for the frame receiver checker.
`ifndef CRC16_FRAME_RECEIVER_WITH_ACK_TOP_MACROS_SVH
`define CRC16_FRAME_RECEIVER_WITH_ACK_TOP_MACROS_SVH

// Check a property on the checker clock, off during reset.
`define CRC16FR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("crc16fr: property failed");

// Check an implication whose consequent must hold in the cycle after the antecedent.
`define CRC16FR_ASSERT_NEXT(lbl, ante, cons) \
    `CRC16FR_ASSERT(lbl, (ante) |=> (cons))

`endif

### hw/rtl/crc16fr_pkg.sv
`timescale 1ns / 1ps
package crc16fr_pkg;

    localparam logic [7:0]  START_BYTE = 8'h81;
    localparam logic [7:0]  STOP_BYTE  = 8'h00;
    localparam logic [7:0]  ACK_CTRL   = 8'hF0;
    localparam logic [7:0]  NACK_CTRL  = 8'hF1;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam int          CTRL_FLAG_BIT = 7;
    localparam int          ACK_REQ_BIT   = 3;

    localparam logic [2:0] EV_PAYLOAD    = 3'd0;
    localparam logic [2:0] EV_FRAME_OK   = 3'd1;
    localparam logic [2:0] EV_CRC_ERR    = 3'd2;
    localparam logic [2:0] EV_DSTOP_MISS = 3'd3;
    localparam logic [2:0] EV_CTRL_FRAME = 3'd4;
    localparam logic [2:0] EV_CSTOP_MISS = 3'd5;
    localparam logic [2:0] EV_TX_BYTE    = 3'd6;

    localparam logic [2:0] CODE_INVALID  = 3'd5;
    localparam logic [3:0] CODE_MAX      = 4'd4;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/crc16_frame_receiver_with_ack_top.sv
`timescale 1ns / 1ps
// Serial frame receiver with CRC-16 check and ACK/NACK reply words.
// Input channel: i_rx_valid / o_rx_stall carry one received byte (i_rx_byte)
// per word. Output channel: o_res_valid / i_res_stall carry one result word
// (event, data byte, control code, payload length, last flag).
// Frames: 0x81, control byte, then either a stop byte (control frame) or
// count, payload, CRC high, CRC low, stop byte (data frame). Payload bytes
// stream out as they arrive; the verdict word follows at the stop byte, and
// a reply of three transmit words (81 F0 00 or 81 F1 00) may follow it.
// A result word is registered and appears in the cycle after the byte that
// causes it. Throughput: one byte per cycle while i_res_stall is low; a byte
// that causes a reply holds the input stalled until the last reply word is
// shown, since the result register drains one word per unstalled cycle.
// Reset (synchronous, active low) returns to hunting for the start byte and
// empties the result register.
// While the receiver stalls, the result word holds and the input stalls
// once the result register cannot take the next byte's word.
module crc16_frame_receiver_with_ack_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [2:0] o_event_res,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_control_code,
    output logic [7:0] o_payload_length,
    output logic       o_last
);
    import crc16fr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT, PH_CTRL, PH_COUNT, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO, PH_DSTOP, PH_CSTOP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_remain, n_remain;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rx_crc, n_rx_crc;

    logic        r_valid, n_valid;
    logic [2:0]  r_event, n_event;
    logic [7:0]  r_data, n_data;
    logic [2:0]  r_code, n_code;
    logic [7:0]  r_len, n_len;
    logic        r_last, n_last;
    logic [1:0]  r_rem, n_rem;
    logic        r_nack, n_nack;

    logic        in_acc;
    logic        out_fire;
    logic [15:0] crc_in;

    assign out_fire   = r_valid && !i_res_stall;
    assign o_rx_stall = r_valid && !(out_fire && (r_rem == 2'd0));
    assign in_acc     = i_rx_valid && !o_rx_stall;
    assign crc_in     = (r_phase == PH_CTRL) ? 16'h0000 : r_crc;

    always_comb begin
        n_phase  = r_phase;
        n_ctrl   = r_ctrl;
        n_count  = r_count;
        n_remain = r_remain;
        n_crc    = r_crc;
        n_rx_crc = r_rx_crc;
        n_valid  = r_valid;
        n_event  = r_event;
        n_data   = r_data;
        n_code   = r_code;
        n_len    = r_len;
        n_last   = r_last;
        n_rem    = r_rem;
        n_nack   = r_nack;

        if (out_fire && (r_rem != 2'd0)) begin
            n_event = EV_TX_BYTE;
            n_code  = 3'd0;
            n_len   = 8'd0;
            n_last  = (r_rem == 2'd1);
            n_rem   = r_rem - 2'd1;
            case (r_rem)
                2'd3:    n_data = START_BYTE;
                2'd2:    n_data = r_nack ? NACK_CTRL : ACK_CTRL;
                default: n_data = STOP_BYTE;
            endcase
        end else if (in_acc) begin
            n_valid = 1'b0;
            n_data  = 8'd0;
            n_code  = 3'd0;
            n_len   = 8'd0;
            n_last  = 1'b1;
            n_rem   = 2'd0;
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == START_BYTE) begin
                        n_phase = PH_CTRL;
                    end
                end
                PH_CTRL: begin
                    n_ctrl = i_rx_byte;
                    if (i_rx_byte[CTRL_FLAG_BIT]) begin
                        n_phase = PH_CSTOP;
                    end else begin
                        n_crc   = crc16_byte(crc_in, i_rx_byte);
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    n_count  = i_rx_byte;
                    n_remain = i_rx_byte;
                    n_crc    = crc16_byte(crc_in, i_rx_byte);
                    n_phase  = (i_rx_byte == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_crc    = crc16_byte(crc_in, i_rx_byte);
                    n_valid  = 1'b1;
                    n_event  = EV_PAYLOAD;
                    n_data   = i_rx_byte;
                    n_remain = r_remain - 8'd1;
                    if (r_remain == 8'd1) begin
                        n_phase = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    n_rx_crc = {i_rx_byte, 8'h00};
                    n_phase  = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    n_rx_crc = {r_rx_crc[15:8], i_rx_byte};
                    n_phase  = PH_DSTOP;
                end
                PH_DSTOP: begin
                    n_valid = 1'b1;
                    n_len   = r_count;
                    n_phase = PH_HUNT;
                    if (i_rx_byte != STOP_BYTE) begin
                        n_event = EV_DSTOP_MISS;
                    end else if (r_rx_crc != r_crc) begin
                        n_event = EV_CRC_ERR;
                        n_rem   = 2'd3;
                        n_nack  = 1'b1;
                        n_last  = 1'b0;
                    end else begin
                        n_event = EV_FRAME_OK;
                        n_nack  = 1'b0;
                        if (r_ctrl[ACK_REQ_BIT]) begin
                            n_rem  = 2'd3;
                            n_last = 1'b0;
                        end
                    end
                end
                PH_CSTOP: begin
                    n_valid = 1'b1;
                    n_phase = PH_HUNT;
                    if (i_rx_byte != STOP_BYTE) begin
                        n_event = EV_CSTOP_MISS;
                    end else begin
                        n_event = EV_CTRL_FRAME;
                        n_code  = (r_ctrl[3:0] > CODE_MAX) ? CODE_INVALID : r_ctrl[2:0];
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end else if (out_fire) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl   <= n_ctrl;
        r_count  <= n_count;
        r_remain <= n_remain;
        r_crc    <= n_crc;
        r_rx_crc <= n_rx_crc;
        r_event  <= n_event;
        r_data   <= n_data;
        r_code   <= n_code;
        r_len    <= n_len;
        r_last   <= n_last;
        r_nack   <= n_nack;
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_valid <= 1'b0;
            r_rem   <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
            r_rem   <= n_rem;
        end
    end

    assign o_res_valid      = r_valid;
    assign o_event_res      = r_event;
    assign o_data_byte      = r_data;
    assign o_control_code   = r_code;
    assign o_payload_length = r_len;
    assign o_last           = r_last;

endmodule

### hw/rtl/crc16fr_checker.sv
`timescale 1ns / 1ps
`include "crc16_frame_receiver_with_ack_top_macros.svh"
module crc16fr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_rx_stall,
    input logic       o_res_valid,
    input logic       i_res_stall,
    input logic [2:0] o_event_res,
    input logic [7:0] o_data_byte,
    input logic [2:0] o_control_code,
    input logic       o_last
);
    import crc16fr_pkg::*;

    logic [14:0] res_word;
    logic        res_hold;
    logic        verdict_out;
    logic        tx_start;
    logic        other_event;

    assign res_word    = {o_event_res, o_data_byte, o_control_code, o_last};
    assign res_hold    = o_res_valid && i_res_stall;
    assign verdict_out = o_res_valid && !i_res_stall && !o_last &&
                         (o_event_res == EV_FRAME_OK || o_event_res == EV_CRC_ERR);
    assign tx_start    = o_res_valid && (o_event_res == EV_TX_BYTE) &&
                         (o_data_byte == START_BYTE);
    assign other_event = o_res_valid && (o_event_res != EV_CTRL_FRAME);

    `CRC16FR_ASSERT_NEXT(a_res_hold, res_hold, o_res_valid && $stable(res_word))
    `CRC16FR_ASSERT(a_reply_blocks_input, (o_res_valid && !o_last) |-> o_rx_stall)
    `CRC16FR_ASSERT_NEXT(a_reply_start, verdict_out, tx_start)
    `CRC16FR_ASSERT(a_code_only_ctrl, other_event |-> (o_control_code == 3'd0))

endmodule

bind crc16_frame_receiver_with_ack_top crc16fr_checker u_crc16fr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_rx_stall     (o_rx_stall),
    .o_res_valid    (o_res_valid),
    .i_res_stall    (i_res_stall),
    .o_event_res    (o_event_res),
    .o_data_byte    (o_data_byte),
    .o_control_code (o_control_code),
    .o_last         (o_last)
);
